/* sv/s2a_pkg.sv */
package s2a_pkg;

  localparam int FIFO_DEPTH_DEF = 256;
  localparam int CMD_Q_DEPTH    = 2;
  localparam int OUT_Q_DEPTH    = 4;
  localparam int FILL_W         = 9;
  localparam int CHAR_W         = 7;

  localparam logic       FUNC_BYTE   = 1'b0;
  localparam logic       FUNC_READ   = 1'b1;
  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [7:0] LEFT_SHIFT  = 8'h2A;
  localparam logic [7:0] RIGHT_SHIFT = 8'h36;

  typedef struct packed {
    logic       func;
    logic [7:0] scancode;
  } in_beat_t;

  typedef struct packed {
    logic              char_valid;
    logic [CHAR_W-1:0] char_code;
    logic              overflow;
    logic [FILL_W-1:0] fill_level;
    logic              shift_held;
  } out_beat_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_PUSH,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] ch;
    logic              shift;
  } cmd_t;

  // US layout, scancode set 1 make codes; 0 = no character
  function automatic logic [CHAR_W-1:0] key_map(input logic shift, input logic [6:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      7'd2:    c = shift ? 7'h21 : 7'h31;
      7'd3:    c = shift ? 7'h40 : 7'h32;
      7'd4:    c = shift ? 7'h23 : 7'h33;
      7'd5:    c = shift ? 7'h24 : 7'h34;
      7'd6:    c = shift ? 7'h25 : 7'h35;
      7'd7:    c = shift ? 7'h5E : 7'h36;
      7'd8:    c = shift ? 7'h26 : 7'h37;
      7'd9:    c = shift ? 7'h2A : 7'h38;
      7'd10:   c = shift ? 7'h28 : 7'h39;
      7'd11:   c = shift ? 7'h29 : 7'h30;
      7'd12:   c = shift ? 7'h5F : 7'h2D;
      7'd13:   c = shift ? 7'h2B : 7'h3D;
      7'd14:   c = 7'h08;
      7'd15:   c = 7'h09;
      7'd16:   c = shift ? 7'h51 : 7'h71;
      7'd17:   c = shift ? 7'h57 : 7'h77;
      7'd18:   c = shift ? 7'h45 : 7'h65;
      7'd19:   c = shift ? 7'h52 : 7'h72;
      7'd20:   c = shift ? 7'h54 : 7'h74;
      7'd21:   c = shift ? 7'h59 : 7'h79;
      7'd22:   c = shift ? 7'h55 : 7'h75;
      7'd23:   c = shift ? 7'h49 : 7'h69;
      7'd24:   c = shift ? 7'h4F : 7'h6F;
      7'd25:   c = shift ? 7'h50 : 7'h70;
      7'd26:   c = shift ? 7'h7B : 7'h5B;
      7'd27:   c = shift ? 7'h7D : 7'h5D;
      7'd28:   c = 7'h0A;
      7'd30:   c = shift ? 7'h41 : 7'h61;
      7'd31:   c = shift ? 7'h53 : 7'h73;
      7'd32:   c = shift ? 7'h44 : 7'h64;
      7'd33:   c = shift ? 7'h46 : 7'h66;
      7'd34:   c = shift ? 7'h47 : 7'h67;
      7'd35:   c = shift ? 7'h48 : 7'h68;
      7'd36:   c = shift ? 7'h4A : 7'h6A;
      7'd37:   c = shift ? 7'h4B : 7'h6B;
      7'd38:   c = shift ? 7'h4C : 7'h6C;
      7'd39:   c = shift ? 7'h3A : 7'h3B;
      7'd40:   c = shift ? 7'h22 : 7'h27;
      7'd41:   c = shift ? 7'h7E : 7'h60;
      7'd43:   c = shift ? 7'h7C : 7'h5C;
      7'd44:   c = shift ? 7'h5A : 7'h7A;
      7'd45:   c = shift ? 7'h58 : 7'h78;
      7'd46:   c = shift ? 7'h43 : 7'h63;
      7'd47:   c = shift ? 7'h56 : 7'h76;
      7'd48:   c = shift ? 7'h42 : 7'h62;
      7'd49:   c = shift ? 7'h4E : 7'h6E;
      7'd50:   c = shift ? 7'h4D : 7'h6D;
      7'd51:   c = shift ? 7'h3C : 7'h2C;
      7'd52:   c = shift ? 7'h3E : 7'h2E;
      7'd53:   c = shift ? 7'h3F : 7'h2F;
      7'd55:   c = 7'h2A;
      7'd57:   c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* sv/s2a_queue.sv */
module s2a_queue #(
  parameter int DEPTH = 2,
  parameter int W     = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [W-1:0]               wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [W-1:0]               rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [W-1:0]     slot_r [DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [LVL_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == LVL_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign level   = cnt_r;
  assign rd_data = slot_r[head_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      tail_nxt = (tail_r == LAST) ? '0 : tail_r + 1'b1;
    end
    if (do_rd) begin
      head_nxt = (head_r == LAST) ? '0 : head_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[tail_r] <= wr_data;
    end
  end

endmodule

/* sv/s2a_front.sv */
module s2a_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  s2a_pkg::in_beat_t  beat,
  output s2a_pkg::cmd_t      cmd
);

  logic       shift_r, shift_nxt;
  logic       prefix_r, prefix_nxt;
  logic [6:0] make_code;

  assign make_code = beat.scancode[6:0];

  always_comb begin
    shift_nxt  = shift_r;
    prefix_nxt = prefix_r;
    cmd.kind   = s2a_pkg::CMD_NOP;
    cmd.ch     = '0;
    if (beat.func == s2a_pkg::FUNC_READ) begin
      cmd.kind = s2a_pkg::CMD_READ;
    end else if (beat.scancode == s2a_pkg::PREFIX_BYTE) begin
      prefix_nxt = 1'b1;
    end else if (prefix_r) begin
      prefix_nxt = 1'b0;           // extended key: dropped
    end else if (beat.scancode[7]) begin
      if ({1'b0, make_code} inside {s2a_pkg::LEFT_SHIFT, s2a_pkg::RIGHT_SHIFT}) begin
        shift_nxt = 1'b0;
      end
    end else if (beat.scancode inside {s2a_pkg::LEFT_SHIFT, s2a_pkg::RIGHT_SHIFT}) begin
      shift_nxt = 1'b1;
    end else begin
      cmd.ch = s2a_pkg::key_map(shift_r, make_code);
      if (cmd.ch != '0) begin
        cmd.kind = s2a_pkg::CMD_PUSH;
      end
    end
    cmd.shift = shift_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= 1'b0;
      prefix_r <= 1'b0;
    end else if (accept) begin
      shift_r  <= shift_nxt;
      prefix_r <= prefix_nxt;
    end
  end

endmodule

/* sv/s2a_back.sv */
module s2a_back #(
  parameter int FIFO_DEPTH = s2a_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      cmd_valid,
  input  s2a_pkg::cmd_t                             cmd,
  output logic                                      cmd_pop,
  input  logic [$clog2(s2a_pkg::OUT_Q_DEPTH+1)-1:0] oq_level,
  output logic                                      res_valid,
  output s2a_pkg::out_beat_t                        res
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int LVL_W = $clog2(s2a_pkg::OUT_Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [s2a_pkg::CHAR_W-1:0] mem [FIFO_DEPTH];
  logic [s2a_pkg::CHAR_W-1:0] mem_q_r;

  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             s1_valid_r;
  logic             s1_rd_r;
  logic             s1_ovf_r;
  logic             s1_shift_r;
  logic [s2a_pkg::FILL_W-1:0] s1_fill_r;

  logic [LVL_W:0] used;
  logic           is_full, is_empty, do_push, do_rd, ovf;

  // credit: the stage-1 beat and the queued results must fit the output queue
  assign used     = {1'b0, oq_level} + (LVL_W + 1)'(s1_valid_r);
  assign cmd_pop  = cmd_valid && (used < (LVL_W + 1)'(s2a_pkg::OUT_Q_DEPTH));
  assign is_full  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign is_empty = (cnt_r == '0);
  assign do_push  = cmd_pop && (cmd.kind == s2a_pkg::CMD_PUSH) && !is_full;
  assign ovf      = cmd_pop && (cmd.kind == s2a_pkg::CMD_PUSH) && is_full;
  assign do_rd    = cmd_pop && (cmd.kind == s2a_pkg::CMD_READ) && !is_empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt  = (wp_r == LAST) ? '0 : wp_r + 1'b1;
      cnt_nxt = cnt_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt  = (rp_r == LAST) ? '0 : rp_r + 1'b1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      rp_r       <= rp_nxt;
      cnt_r      <= cnt_nxt;
      s1_valid_r <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_rd_r    <= do_rd;
      s1_ovf_r   <= ovf;
      s1_shift_r <= cmd.shift;
      s1_fill_r  <= s2a_pkg::FILL_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= cmd.ch;
    end
    if (do_rd) begin
      mem_q_r <= mem[rp_r];
    end
  end

  assign res_valid      = s1_valid_r;
  assign res.char_valid = s1_rd_r;
  assign res.char_code  = s1_rd_r ? mem_q_r : '0;
  assign res.overflow   = s1_ovf_r;
  assign res.fill_level = s1_fill_r;
  assign res.shift_held = s1_shift_r;

endmodule

/* sv/scancode_to_ascii_with_fifo_unit.sv */
// channel  | ports                       | beat accepted when
// ---------+-----------------------------+--------------------
// input    | push, full, in_data         | push && !full
// result   | empty, pop, out_data        | pop && !empty
//
// One beat per cycle sustained while pop keeps up; one result beat per input beat.
// A result reaches out_data through the command queue, then the registered
// character store read and stage-1 registers, then the result queue.
// Character store: FIFO_DEPTH x 7 bits, one write and one registered read port.
// Reset (rst_n low, synchronous) empties both queues and clears shift/prefix.
// Stalls on pop back up through the result queue credit into full.
module scancode_to_ascii_with_fifo_unit #(
  parameter int FIFO_DEPTH = s2a_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  s2a_pkg::in_beat_t  in_data,
  output logic               empty,
  input  logic               pop,
  output s2a_pkg::out_beat_t out_data
);

  localparam int CMD_W = $bits(s2a_pkg::cmd_t);
  localparam int OUT_W = $bits(s2a_pkg::out_beat_t);
  localparam int LVL_W = $clog2(s2a_pkg::OUT_Q_DEPTH + 1);

  s2a_pkg::cmd_t      cmd_in, cmd_out;
  s2a_pkg::out_beat_t res;
  logic               accept;
  logic               cq_empty, cq_pop;
  logic [$clog2(s2a_pkg::CMD_Q_DEPTH+1)-1:0] cq_level;
  logic               oq_full;
  logic [LVL_W-1:0]   oq_level;
  logic               res_valid;
  logic [CMD_W-1:0]   cq_rd;
  logic [OUT_W-1:0]   oq_rd;

  assign accept = push && !full;

  // front: tracks shift/prefix, turns each beat into a command
  s2a_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .beat   (in_data),
    .cmd    (cmd_in)
  );

  // decouples the front from store/result backpressure
  s2a_queue #(
    .DEPTH (s2a_pkg::CMD_Q_DEPTH),
    .W     (CMD_W)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cq_pop),
    .rd_data (cq_rd),
    .empty   (cq_empty),
    .level   (cq_level)
  );

  assign cmd_out = s2a_pkg::cmd_t'(cq_rd);

  // back: character store, pointers, fill count, overflow
  s2a_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cq_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cq_pop),
    .oq_level  (oq_level),
    .res_valid (res_valid),
    .res       (res)
  );

  // result queue; the back stage never pushes into it when full (credit)
  s2a_queue #(
    .DEPTH (s2a_pkg::OUT_Q_DEPTH),
    .W     (OUT_W)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid && !oq_full),
    .wr_data (res),
    .full    (oq_full),
    .rd_en   (pop),
    .rd_data (oq_rd),
    .empty   (empty),
    .level   (oq_level)
  );

  assign out_data = s2a_pkg::out_beat_t'(oq_rd);

endmodule

/* sv/s2a_checker.sv */
module s2a_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input s2a_pkg::out_beat_t out_data
);

  // a popped character is never NUL
  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.char_valid) |-> (out_data.char_code != '0))
    else $error("valid char with zero code");

  // no character -> zero code
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.char_valid) |-> (out_data.char_code == '0))
    else $error("code nonzero without valid char");

  // a read never reports overflow
  a_rd_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_data.char_valid && out_data.overflow))
    else $error("read beat flagged overflow");

  // reset leaves no result and room for input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("result beat changed under stall");

endmodule

bind scancode_to_ascii_with_fifo_unit s2a_checker u_s2a_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);

/* test/tb_scancode_to_ascii_with_fifo_unit.sv */
module tb_scancode_to_ascii_with_fifo_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import s2a_pkg::*;

  localparam int CHAR_DEPTH   = FIFO_DEPTH_DEF;
  localparam int RANDOM_BEATS = 2000;
  localparam int TAIL_BEATS   = 200;      // last stretch of the run: no idling
  localparam int HOLDOFF_AT   = 700;      // input beats taken before the long pop stall
  localparam int HOLDOFF_CYC  = 400;
  localparam int LIMIT_CYCLES = 400_000;
  localparam logic [7:0] RELEASE_BIT = 8'h80;

  typedef enum int {TYPING, DRAINING, FLOODING} phase_kind_t;

  // Keyboard decoder predictor: shift/prefix flags plus the characters
  // that should be sitting in the block's character FIFO right now.
  class keymap_checker;
    bit              shift;
    bit              prefix;
    bit [6:0]        typed_chars [$];
    out_beat_t       replies_due [$];
    int              errors;

    // US layout, set 1 make codes, 0 when the key gives no character
    static function bit [6:0] key_char(bit upper, bit [6:0] code);
      string lo;
      string hi;
      int    base;
      bit [6:0] c;
      c = '0;
      base = -1;
      if (code >= 2 && code <= 13) begin
        lo = "1234567890-="; hi = "!@#$%^&*()_+"; base = 2;
      end else if (code >= 16 && code <= 27) begin
        lo = "qwertyuiop[]"; hi = "QWERTYUIOP{}"; base = 16;
      end else if (code >= 30 && code <= 40) begin
        lo = "asdfghjkl;'"; hi = "ASDFGHJKL:\""; base = 30;
      end else if (code >= 43 && code <= 53) begin
        lo = "\\zxcvbnm,./"; hi = "|ZXCVBNM<>?"; base = 43;
      end else begin
        case (code)
          7'd14:   c = 7'h08;             // backspace
          7'd15:   c = 7'h09;             // tab
          7'd28:   c = 7'h0A;             // enter
          7'd41:   c = upper ? 7'h7E : 7'h60;
          7'd55:   c = 7'h2A;             // keypad star
          7'd57:   c = 7'h20;             // space bar
          default: c = '0;
        endcase
      end
      if (base >= 0)
        c = upper ? 7'(hi[code - base]) : 7'(lo[code - base]);
      return c;
    endfunction

    // returns 1 when a decoded character is lost to a full FIFO
    function bit take_scancode(bit [7:0] sc);
      bit [6:0] ch;
      if (sc == PREFIX_BYTE) begin
        prefix = 1'b1;
        return 1'b0;
      end
      if (prefix) begin
        prefix = 1'b0;
        return 1'b0;
      end
      if (sc[7]) begin
        if (sc[6:0] == LEFT_SHIFT[6:0] || sc[6:0] == RIGHT_SHIFT[6:0])
          shift = 1'b0;
        return 1'b0;
      end
      if (sc == LEFT_SHIFT || sc == RIGHT_SHIFT) begin
        shift = 1'b1;
        return 1'b0;
      end
      ch = key_char(shift, sc[6:0]);
      if (ch == '0)
        return 1'b0;
      if (typed_chars.size() >= CHAR_DEPTH)
        return 1'b1;
      typed_chars.push_back(ch);
      return 1'b0;
    endfunction

    function void note_request(in_beat_t b);
      out_beat_t want;
      want = '0;
      if (b.func == FUNC_READ) begin
        if (typed_chars.size() != 0) begin
          want.char_valid = 1'b1;
          want.char_code  = typed_chars.pop_front();
        end
      end else begin
        want.overflow = take_scancode(b.scancode);
      end
      want.fill_level = FILL_W'(typed_chars.size());
      want.shift_held = shift;
      replies_due.push_back(want);
    endfunction

    function int due();
      return replies_due.size();
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40)
        $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    task check_reply(out_beat_t got);
      out_beat_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("reply %h with nothing outstanding", got));
        return;
      end
      want = replies_due.pop_front();
      if (got.char_valid !== want.char_valid)
        report($sformatf("char_valid got %b want %b", got.char_valid, want.char_valid));
      if (got.char_code !== want.char_code)
        report($sformatf("char_code got %h want %h", got.char_code, want.char_code));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow got %b want %b", got.overflow, want.overflow));
      if (got.fill_level !== want.fill_level)
        report($sformatf("fill_level got %0d want %0d", got.fill_level, want.fill_level));
      if (got.shift_held !== want.shift_held)
        report($sformatf("shift_held got %b want %b", got.shift_held, want.shift_held));
    endtask
  endclass

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  in_beat_t  in_data = '0;
  logic      full;
  logic      empty;
  out_beat_t out_data;

  keymap_checker chk = new();
  int  beats_in   = 0;
  bit  tail_quiet = 1'b0;
  bit  held_off   = 1'b0;

  // Opening script: empty read, table extremes, both shift keys,
  // prefix handling (including a re-armed prefix and a prefixed shift
  // release that must be swallowed), a non-shift release, then reads that
  // drain everything plus one more on an empty FIFO.
  in_beat_t opening [$] = '{
    {FUNC_READ, 8'hFF},                       // empty read, scancode ignored
    {FUNC_BYTE, 8'h00},                       // lowest code, unmapped
    {FUNC_BYTE, 8'h02},                       // '1'
    {FUNC_BYTE, LEFT_SHIFT},
    {FUNC_BYTE, 8'h02},                       // '!'
    {FUNC_BYTE, 8'h39},                       // space, same either way
    {FUNC_BYTE, LEFT_SHIFT | RELEASE_BIT},
    {FUNC_BYTE, RIGHT_SHIFT},
    {FUNC_BYTE, 8'h35},                       // '?'
    {FUNC_BYTE, PREFIX_BYTE},
    {FUNC_BYTE, RIGHT_SHIFT | RELEASE_BIT},   // eaten by prefix, shift stays
    {FUNC_BYTE, 8'h10},                       // 'Q'
    {FUNC_BYTE, RIGHT_SHIFT | RELEASE_BIT},
    {FUNC_BYTE, PREFIX_BYTE},
    {FUNC_BYTE, PREFIX_BYTE},                 // re-arms
    {FUNC_BYTE, 8'h1C},                       // eaten
    {FUNC_BYTE, 8'h7F},                       // top make code, unmapped
    {FUNC_BYTE, 8'hFF},                       // release, not a shift
    {FUNC_BYTE, 8'h0E},                       // backspace
    {FUNC_READ, 8'h00},
    {FUNC_READ, 8'h55},
    {FUNC_READ, 8'hAA},
    {FUNC_READ, 8'h00},
    {FUNC_READ, 8'hFF},
    {FUNC_READ, 8'h00},
    {FUNC_READ, 8'h00}                        // empty again
  };

  scancode_to_ascii_with_fifo_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: generous multiple of the slowest legal run.
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
        $display("scancode_to_ascii_with_fifo_unit verification failed");
        $finish;
      end
    end
  end

  // Both handshakes sampled at the rising edge; inputs go into the
  // predictor first so a same-edge result can still find its entry.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        chk.note_request(in_data);
        beats_in++;
      end
      if (pop && !empty)
        chk.check_reply(out_data);
    end
  end

  // Result side: runs of pop high mixed with short stalls, one long
  // hold-off so the block backs up into full, and steady pop at the tail.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_off && beats_in >= HOLDOFF_AT) begin
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (HOLDOFF_CYC) @(negedge clk);
        pop <= 1'b1;
      end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_beat(in_beat_t b);
    push    <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    push    <= 1'b0;
    in_data <= {1'($urandom), 8'($urandom)};
    repeat (n) @(negedge clk);
  endtask

  // a make code that always yields a character
  function automatic bit [7:0] typed_key();
    bit [6:0] c;
    do c = 7'($urandom_range(1, 57)); while (keymap_checker::key_char(1'b0, c) == '0);
    return {1'b0, c};
  endfunction

  function automatic bit [7:0] random_scancode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 8'($urandom_range(0, 88));
    if (r < 65) return $urandom_range(0, 1) ? LEFT_SHIFT : RIGHT_SHIFT;
    if (r < 75) return ($urandom_range(0, 1) ? LEFT_SHIFT : RIGHT_SHIFT) | RELEASE_BIT;
    if (r < 80) return PREFIX_BYTE;
    if (r < 88) return RELEASE_BIT | 8'($urandom_range(0, 127));
    return 8'($urandom);
  endfunction

  function automatic in_beat_t make_beat(phase_kind_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      TYPING:   return (r < 85) ? {FUNC_BYTE, random_scancode()}
                                : {FUNC_READ, 8'($urandom)};
      DRAINING: return (r < 85) ? {FUNC_READ, 8'($urandom)}
                                : {FUNC_BYTE, random_scancode()};
      default:  return (r < 90) ? {FUNC_BYTE, typed_key()}
                                : {FUNC_BYTE, random_scancode()};
    endcase
  endfunction

  initial begin
    int          sent;
    int          phase_no;
    int          len;
    int          r;
    phase_kind_t kind;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (opening[i])
      send_beat(opening[i]);

    // Random part in phases: typing bursts, draining bursts, and floods of
    // keystrokes, each flood longer than the FIFO depth.
    sent = 0;
    phase_no = 0;
    while (sent < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (phase_no == 2 || r < 6) begin
        kind = FLOODING;
        len  = $urandom_range(CHAR_DEPTH + 20, CHAR_DEPTH + 70);
      end else if (r < 55) begin
        kind = TYPING;
        len  = $urandom_range(20, 80);
      end else begin
        kind = DRAINING;
        len  = $urandom_range(20, 150);
      end
      for (int i = 0; i < len && sent < RANDOM_BEATS; i++) begin
        tail_quiet = (RANDOM_BEATS - sent) <= TAIL_BEATS;
        if (!tail_quiet && $urandom_range(0, 7) == 0)
          idle_gap($urandom_range(1, 15));
        send_beat(make_beat(kind));
        sent++;
      end
      phase_no++;
    end
    push <= 1'b0;

    // wait for every due reply, then keep clocking to catch strays
    while (chk.due() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (chk.errors == 0)
      $display("scancode_to_ascii_with_fifo_unit verification clean");
    else
      $display("scancode_to_ascii_with_fifo_unit verification failed");
    $finish;
  end

endmodule

/* scancode_to_ascii_with_fifo_unit.f */
sv/s2a_pkg.sv
sv/s2a_queue.sv
sv/s2a_front.sv
sv/s2a_back.sv
sv/scancode_to_ascii_with_fifo_unit.sv
sv/s2a_checker.sv
test/tb_scancode_to_ascii_with_fifo_unit.sv
